### rtl/ssid_pkg.sv
// Shared types and constants for the sorted set insert/delete block.
`timescale 1ns / 1ps
`default_nettype none

package ssid_pkg;

    localparam int CAPACITY      = 16;
    localparam int KEY_W         = 32;
    localparam int COUNT_W       = $clog2(CAPACITY + 1);
    localparam int ENTRY_COUNT_W = 5;
    localparam int STATUS_W      = 3;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_APPLY
    } ctrl_state_t;

    typedef struct packed {
        logic               action;
        logic signed [KEY_W-1:0] key_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic compare;
        logic ins;
        logic del;
    } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/sorted_set_insert_delete.sv
// Top level: chain of sorted cells with a small sequencer and a result register.
//
//   channel | direction | payload | handshake
//   req     | in        | req_t   | req_valid / req_ready
//   rsp     | out       | rsp_t   | rsp_valid / rsp_ready
//
// An item is handled in order: accept and latch the key, compare in every cell,
// then apply the shift in every cell and load the result register.
// The next item is accepted once the chain is back in idle, even while a
// result still waits in the result register; apply holds while it is full.
// Reset clears all valid bits and the entry count; stored values need no reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_insert_delete (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire ssid_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output ssid_pkg::rsp_t      rsp
);
    import ssid_pkg::*;

    ctrl_state_t              state_reg;
    ctrl_state_t              state_next;
    logic                     action_reg;
    logic signed [KEY_W-1:0]  key_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    cell_cmd_t                cmd;
    logic signed [KEY_W-1:0]  cell_value [CAPACITY];
    logic [CAPACITY-1:0]      cell_valid;
    logic [CAPACITY-1:0]      cell_lt;
    logic [CAPACITY-1:0]      cell_eq;

    logic                     found;
    logic                     full;
    logic                     empty;
    logic                     apply_fire;
    status_t                  status;

    assign found = |cell_eq;
    assign full  = cell_valid[CAPACITY-1];
    assign empty = !cell_valid[0];

    assign req_ready  = (state_reg == S_IDLE);
    assign apply_fire = (state_reg == S_APPLY) && (!rsp_valid_reg || rsp_ready);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [KEY_W-1:0] lv;
            logic                    lvld;
            logic                    llt;
            logic signed [KEY_W-1:0] rv;
            logic                    rvld;

            if (g == 0)
            begin : g_first
                assign lv   = key_reg;
                assign lvld = 1'b1;
                assign llt  = 1'b1;
            end
            else
            begin : g_mid
                assign lv   = cell_value[g-1];
                assign lvld = cell_valid[g-1];
                assign llt  = cell_lt[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign rv   = '0;
                assign rvld = 1'b0;
            end
            else
            begin : g_inner
                assign rv   = cell_value[g+1];
                assign rvld = cell_valid[g+1];
            end

            ssid_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .key         (key_reg),
                .left_value  (lv),
                .left_valid  (lvld),
                .left_lt     (llt),
                .right_value (rv),
                .right_valid (rvld),
                .value       (cell_value[g]),
                .valid       (cell_valid[g]),
                .lt          (cell_lt[g]),
                .eq          (cell_eq[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        cmd            = '0;
        status         = ST_OK;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (action_reg == ACT_INSERT)
        begin
            if (found)
            begin
                status = ST_DUPLICATE;
            end
            else if (full)
            begin
                status = ST_FULL;
            end
        end
        else
        begin
            if (empty)
            begin
                status = ST_EMPTY;
            end
            else if (!found)
            begin
                status = ST_NOT_FOUND;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_fire)
                begin
                    if (status == ST_OK)
                    begin
                        if (action_reg == ACT_INSERT)
                        begin
                            cmd.ins    = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            cmd.del    = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    rsp_next.status      = status;
                    rsp_next.entry_count = ENTRY_COUNT_W'(count_next);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (req_valid && req_ready)
        begin
            action_reg <= req.action;
            key_reg    <= req.key_value;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

### rtl/ssid_cell.sv
// One storage cell of the sorted chain: holds a value, compares it and shifts.
`timescale 1ns / 1ps
`default_nettype none

module ssid_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ssid_pkg::cell_cmd_t             cmd,
    input  wire logic signed [ssid_pkg::KEY_W-1:0] key,
    input  wire logic signed [ssid_pkg::KEY_W-1:0] left_value,
    input  wire logic                            left_valid,
    input  wire logic                            left_lt,
    input  wire logic signed [ssid_pkg::KEY_W-1:0] right_value,
    input  wire logic                            right_valid,
    output logic signed [ssid_pkg::KEY_W-1:0]    value,
    output logic                                 valid,
    output logic                                 lt,
    output logic                                 eq
);
    import ssid_pkg::*;

    logic signed [KEY_W-1:0] value_reg;
    logic signed [KEY_W-1:0] value_next;
    logic                    valid_reg;
    logic                    valid_next;
    logic                    lt_reg;
    logic                    eq_reg;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (cmd.ins && !lt_reg)
        begin
            value_next = left_lt ? key : left_value;
            valid_next = valid_reg | left_valid;
        end
        else if (cmd.del && !lt_reg)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.compare)
            begin
                lt_reg <= valid_reg && (value_reg < key);
                eq_reg <= valid_reg && (value_reg == key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

### rtl/ssid_checker.sv
// Port-level checks for the sorted set block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ssid_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire ssid_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire ssid_pkg::rsp_t rsp
);
    import ssid_pkg::*;

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("input item changed while stalled");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= ST_FULL)
        else $error("result status out of range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.entry_count <= ENTRY_COUNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item accepted while one is in work");

endmodule

bind sorted_set_insert_delete ssid_checker u_ssid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

### dv/sorted_set_insert_delete_tb.sv
// Testbench for the sorted set insert/delete block: scoreboard class, handshake drivers, checks.
`timescale 1ns / 1ps

module sorted_set_insert_delete_tb;

    import ssid_pkg::*;

    localparam int RANDOM_ITEMS  = 1250;
    localparam int BLOCK_ITEMS   = 50;
    localparam int CALM_BLOCKS   = 3;
    localparam int POOL_SIZE     = 24;
    localparam int FIXED_KEYS    = 5;
    localparam int HOLD_CYCLES   = 150;
    localparam int BURST_ITEMS   = 12;
    localparam int TAIL_CYCLES   = 12;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int REPORT_LIMIT  = 10;

    class sorted_set_tracker;
        int          keys[CAPACITY];
        int          count;
        rsp_t        pending_rsps[$];
        int unsigned errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("[%0t] %s", $realtime, msg);
        endfunction

        function void note_request(req_t item);
            int      key;
            int      pos;
            int      i;
            status_t st;
            rsp_t    exp_rsp;
            key = item.key_value;
            pos = 0;
            st  = ST_OK;
            while (pos < count && keys[pos] < key)
                pos++;
            if (item.action == ACT_INSERT)
            begin
                if (pos < count && keys[pos] == key)
                    st = ST_DUPLICATE;
                else if (count >= CAPACITY)
                    st = ST_FULL;
                else
                begin
                    for (i = count; i > pos; i--)
                        keys[i] = keys[i - 1];
                    keys[pos] = key;
                    count++;
                end
            end
            else
            begin
                if (count == 0)
                    st = ST_EMPTY;
                else if (pos >= count || keys[pos] != key)
                    st = ST_NOT_FOUND;
                else
                begin
                    for (i = pos; i + 1 < count; i++)
                        keys[i] = keys[i + 1];
                    count--;
                end
            end
            exp_rsp.status      = st;
            exp_rsp.entry_count = count[ENTRY_COUNT_W-1:0];
            pending_rsps.push_back(exp_rsp);
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp_rsp;
            if (pending_rsps.size() == 0)
            begin
                report($sformatf("unexpected item: status %0d count %0d",
                                 got.status, got.entry_count));
                return;
            end
            exp_rsp = pending_rsps.pop_front();
            if (got.status !== exp_rsp.status || got.entry_count !== exp_rsp.entry_count)
                report($sformatf(
                    "mismatch: expected status %0d count %0d, got status %0d count %0d",
                    exp_rsp.status, exp_rsp.entry_count,
                    got.status, got.entry_count));
        endfunction

        function int pending();
            return pending_rsps.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    sorted_set_tracker set_board = new();

    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    bit          hold_off   = 1'b0;
    int unsigned cycle_count = 0;
    int          key_pool[POOL_SIZE];

    sorted_set_insert_delete u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            set_board.check_response(rsp);
    end

    initial
    begin
        forever
        begin
            if (hold_off)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_item(input action_t act, input int key);
        req_t item;
        item.action    = act;
        item.key_value = key;
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        set_board.note_request(item);
    endtask

    task automatic pause_tx(input int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_and_idle(input action_t act, input int key);
        send_item(act, key);
        if (tx_idle_en && $urandom_range(0, 4) == 0)
            pause_tx($urandom_range(1, 4));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (set_board.pending() != 0);
    endtask

    function automatic int pick_key();
        if ($urandom_range(0, 9) < 7)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return int'($urandom);
    endfunction

    initial
    begin
        int      blk;
        int      n;
        int      ins_pct;
        action_t act;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;

        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 0;
        key_pool[3] = -1;
        key_pool[4] = 1;
        for (n = FIXED_KEYS; n < POOL_SIZE; n++)
            key_pool[n] = int'($urandom);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_and_idle(ACT_DELETE, 7);
        send_and_idle(ACT_INSERT, 32'sh8000_0000);
        send_and_idle(ACT_INSERT, 32'sh7fff_ffff);
        send_and_idle(ACT_INSERT, 0);
        send_and_idle(ACT_INSERT, -1);
        send_and_idle(ACT_INSERT, 1);
        send_and_idle(ACT_INSERT, 32'sh7fff_ffff);
        send_and_idle(ACT_DELETE, 5);
        for (n = 2; n <= 12; n++)
            send_and_idle(ACT_INSERT, n * 1000 - 6000);
        send_and_idle(ACT_INSERT, 100);
        send_and_idle(ACT_INSERT, 0);
        send_and_idle(ACT_DELETE, 32'sh8000_0000);
        send_and_idle(ACT_DELETE, 32'sh7fff_ffff);
        send_and_idle(ACT_DELETE, 0);
        wait_drained();

        hold_off = 1'b1;
        for (n = 0; n < BURST_ITEMS; n++)
        begin
            act = ($urandom_range(0, 1) == 0) ? ACT_INSERT : ACT_DELETE;
            send_item(act, pick_key());
        end
        wait_drained();

        for (blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++)
        begin
            if (blk >= RANDOM_ITEMS / BLOCK_ITEMS - CALM_BLOCKS)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            else
            begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            ins_pct = $urandom_range(15, 85);
            for (n = 0; n < 4; n++)
                key_pool[$urandom_range(FIXED_KEYS, POOL_SIZE - 1)] = int'($urandom);
            for (n = 0; n < BLOCK_ITEMS; n++)
            begin
                act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_DELETE;
                send_and_idle(act, pick_key());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (set_board.pending() != 0)
            set_board.report($sformatf("%0d results never arrived", set_board.pending()));

        if (set_board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
